@@ design/tlsm_pkg.sv @@
package tlsm_pkg;

   localparam int LIST_DEPTH_DEF = 16;
   localparam int DATA_W         = 32;
   localparam int OP_W           = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_MERGE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN
   } state_type;

endpackage

@@ design/two_list_sorted_merge.sv @@
// Two-list sorted merge.
// Command channel: a transfer happens on a rising edge with start high and
// busy low. req_opcode selects append to list A, append to list B or merge;
// req_element_value is the appended value (ignored on merge).
// Loads keep busy low; a load into a full list (LIST_DEPTH entries)
// is dropped. Unused opcodes are ignored.
// A merge with both lists empty produces nothing. Otherwise busy rises,
// the setup state ST_PREP primes the RAM reads, then one element per
// cycle is compared in the shared comparator and emitted, ascending,
// list A first on ties. Results reach rsp_* after ST_PREP, via ST_RUN
// and the output registers, one per cycle, rsp_valid high for one cycle
// each; rsp_is_last marks the final one. busy stays high through ST_PREP
// and ST_RUN. Both lists are empty afterwards.
// Results cannot be held off by the receiver.
// Reset empties both lists and returns to idle; RAM contents are not cleared.
module two_list_sorted_merge #(
   parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tlsm_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [tlsm_pkg::DATA_W-1:0] req_element_value,
   output logic                               rsp_valid,
   output logic signed [tlsm_pkg::DATA_W-1:0] rsp_merged_value,
   output logic                               rsp_is_last
);
   import tlsm_pkg::*;

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic              we_a, we_b;
   logic [AW-1:0]     waddr_a, waddr_b, raddr_a, raddr_b;
   logic [DATA_W-1:0] head_a, head_b;

   tlsm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (waddr_a),
      .wr_data (req_element_value),
      .rd_addr (raddr_a),
      .rd_data (head_a)
   );

   tlsm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (waddr_b),
      .wr_data (req_element_value),
      .rd_addr (raddr_b),
      .rd_data (head_b)
   );

   tlsm_ctrl #(.LIST_DEPTH(LIST_DEPTH), .AW(AW)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .head_a           (head_a),
      .head_b           (head_b),
      .we_a             (we_a),
      .we_b             (we_b),
      .waddr_a          (waddr_a),
      .waddr_b          (waddr_b),
      .raddr_a          (raddr_a),
      .raddr_b          (raddr_b),
      .rsp_valid        (rsp_valid),
      .rsp_merged_value (rsp_merged_value),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

@@ design/tlsm_ram.sv @@
module tlsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tlsm_ctrl.sv @@
module tlsm_ctrl #(
   parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF,
   parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tlsm_pkg::OP_W-1:0]          req_opcode,
   input  logic [tlsm_pkg::DATA_W-1:0]        head_a,
   input  logic [tlsm_pkg::DATA_W-1:0]        head_b,
   output logic                               we_a,
   output logic                               we_b,
   output logic [AW-1:0]                      waddr_a,
   output logic [AW-1:0]                      waddr_b,
   output logic [AW-1:0]                      raddr_a,
   output logic [AW-1:0]                      raddr_b,
   output logic                               rsp_valid,
   output logic signed [tlsm_pkg::DATA_W-1:0] rsp_merged_value,
   output logic                               rsp_is_last
);
   import tlsm_pkg::*;

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int SW = CW + 1;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0]     ia_ff, ia_in, ib_ff, ib_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   logic              accept;
   op_type            op;
   logic              a_avail, b_avail, take_a, last;
   logic [SW-1:0]     total, done_cnt;

   assign accept   = start && (state_ff == ST_IDLE);
   assign op       = op_type'(req_opcode);
   assign a_avail  = ia_ff < cnt_a_ff;
   assign b_avail  = ib_ff < cnt_b_ff;
   // shared compare unit; ties go to list A
   assign take_a   = (a_avail && b_avail) ? ($signed(head_a) <= $signed(head_b)) : a_avail;
   assign total    = {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff};
   assign done_cnt = {1'b0, ia_ff} + {1'b0, ib_ff} + SW'(1);
   assign last     = done_cnt == total;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (op == OP_MERGE) && (total != '0)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_RUN;
         ST_RUN: begin
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      we_a         = 1'b0;
      we_b         = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_value_in = take_a ? head_a : head_b;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_LOAD_A: begin
                     if (cnt_a_ff < CW'(LIST_DEPTH)) begin
                        we_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + CW'(1);
                     end
                  end
                  OP_LOAD_B: begin
                     if (cnt_b_ff < CW'(LIST_DEPTH)) begin
                        we_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + CW'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: ;
         ST_RUN: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = last;
            if (last) begin
               cnt_a_in = '0;
               cnt_b_in = '0;
               ia_in    = '0;
               ib_in    = '0;
            end else if (take_a) begin
               ia_in = ia_ff + CW'(1);
            end else begin
               ib_in = ib_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff  <= rsp_last_in;
      rsp_value_ff <= rsp_value_in;
   end

   // read address is taken from the next index value so the head is ready each cycle
   assign raddr_a          = ia_in[AW-1:0];
   assign raddr_b          = ib_in[AW-1:0];
   assign waddr_a          = cnt_a_ff[AW-1:0];
   assign waddr_b          = cnt_b_ff[AW-1:0];
   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_last      = rsp_last_ff;
   assign rsp_merged_value = $signed(rsp_value_ff);

endmodule
